// ----- hdl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// Used by the stream interface, the front and back units and the top level.
package i2cm_pkg;

    localparam int DELAY_COUNT_WIDTH_DEF = 16;
    localparam int CFG_ADDR_W            = 3;
    localparam int CFG_DATA_W            = 32;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [15:0] DELAY_TICKS_RESET = 16'd35;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic        REG_DELAY_TICKS   = 1'b0;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } t_cmd_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C,
        PH_WR_LOW,
        PH_WR_DATA,
        PH_WR_HIGH,
        PH_WA_REL,
        PH_WA_HIGH,
        PH_WA_END,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH
    } t_phase;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } t_res_item;

    // Classified tick as it sits in the queue
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_queue_head;

endpackage

// ----- hdl/i2cm_stream_if.sv -----
// Valid/ready channel carrying one payload item per transaction.
// Depends on i2cm_pkg for the default payload type.
interface i2cm_stream_if #(
    parameter type t_payload = i2cm_pkg::t_in_item
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: APB register, front queue, back sequencer.
// Depends on i2cm_pkg, i2cm_stream_if, i2cm_front and i2cm_back.
//
//  channel   dir  handshake          payload
//  i_item    in   valid/ready        cmd_valid, func, tx_byte, send_ack, sda_in
//  o_result  out  valid/ready        scl_out, sda_out, busy_res, done_res, rx_byte, nack_seen
//  apb       in   psel/penable/pwrite register delay_ticks at byte address 0
//
// One tick in, one result out; sustained rate one tick per cycle while o_result.ready stays high.
// Each tick passes through the two-entry queue and then the result register.
// The result register holds while o_result.ready is low; the queue keeps taking ticks
// until both entries fill. A bus phase lasts delay_ticks ticks (zero counts as one).
// Synchronous active-low reset puts the bus released and the sequencer idle.
module i2c_master_byte_engine #(
    parameter int DELAY_COUNT_WIDTH = i2cm_pkg::DELAY_COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    i2cm_stream_if.sink                         i_item,
    i2cm_stream_if.source                       o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [i2cm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [15:0]           r_delay_ticks;
    logic                  w_cfg_wr;
    logic                  w_pop;
    i2cm_pkg::t_queue_head w_head;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == i2cm_pkg::REG_DELAY_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= i2cm_pkg::DELAY_TICKS_RESET;
        end else if (w_cfg_wr) begin
            r_delay_ticks <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == i2cm_pkg::REG_DELAY_TICKS) ?
                    {16'd0, r_delay_ticks} : '0;

    i2cm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    i2cm_back #(
        .DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_delay_ticks (r_delay_ticks),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_result      (o_result)
    );

`ifndef SYNTHESIS
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("sequencer popped an empty queue");

    a_accept_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && !w_pop) |=> w_head.valid)
        else $error("accepted tick not visible at queue head");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.done_res) |-> !o_result.payload.busy_res)
        else $error("done result still reports busy");
`endif

endmodule

// ----- hdl/i2cm_front.sv -----
// Front unit: accepts ticks, classifies the command and queues them.
// Depends on i2cm_pkg and i2cm_stream_if.
module i2cm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    i2cm_stream_if.sink          i_item,
    input  logic                 i_pop,
    output i2cm_pkg::t_queue_head o_head
);

    localparam int PTR_W = $clog2(i2cm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);

    i2cm_pkg::t_op    r_slot [i2cm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    i2cm_pkg::t_op    w_op;
    logic             w_accept;

    always_comb begin
        w_op.tx_byte  = i_item.payload.tx_byte;
        w_op.send_ack = i_item.payload.send_ack;
        w_op.sda_in   = i_item.payload.sda_in;
        if (!i_item.payload.cmd_valid) begin
            w_op.kind = i2cm_pkg::CMD_NONE;
        end else begin
            case (i_item.payload.func)
                i2cm_pkg::FUNC_START: w_op.kind = i2cm_pkg::CMD_START;
                i2cm_pkg::FUNC_STOP:  w_op.kind = i2cm_pkg::CMD_STOP;
                i2cm_pkg::FUNC_WRITE: w_op.kind = i2cm_pkg::CMD_WRITE;
                default:              w_op.kind = i2cm_pkg::CMD_READ;
            endcase
        end
    end

    assign i_item.ready = (r_count != CNT_W'(i2cm_pkg::QUEUE_DEPTH));
    assign w_accept     = i_item.valid && i_item.ready;

    always_comb begin
        n_wr_ptr = w_accept ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(w_accept) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot[r_wr_ptr] <= w_op;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_slot[r_rd_ptr];

endmodule

// ----- hdl/i2cm_back.sv -----
// Back unit: bus phase sequencer with delay counter and result register.
// Depends on i2cm_pkg and i2cm_stream_if.
module i2cm_back #(
    parameter int DELAY_COUNT_WIDTH = i2cm_pkg::DELAY_COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_delay_ticks,
    input  i2cm_pkg::t_queue_head i_head,
    output logic                  o_pop,
    i2cm_stream_if.source         o_result
);

    localparam int DW = DELAY_COUNT_WIDTH;

    i2cm_pkg::t_phase   r_phase, n_phase;
    logic [3:0]         r_bit_index, n_bit_index;
    logic [7:0]         r_shift, n_shift;
    logic [DW-1:0]      r_wait, n_wait;
    logic               r_ack_choice, n_ack_choice;
    logic [7:0]         r_received, n_received;
    logic               r_nack, n_nack;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               r_res_valid;
    i2cm_pkg::t_res_item r_res;

    logic          w_idle;
    logic          w_fire;
    logic          w_done;
    logic [3:0]    w_bit_inc;
    logic [DW-1:0] w_delay_masked;
    logic [DW-1:0] w_load;

    assign o_pop  = i_head.valid && (!r_res_valid || o_result.ready);
    assign w_idle = (r_phase == i2cm_pkg::PH_IDLE);
    assign w_fire = !w_idle && (r_wait <= DW'(1));
    assign w_done = w_fire && (n_phase == i2cm_pkg::PH_IDLE);
    assign w_bit_inc = r_bit_index + 4'd1;

    assign w_delay_masked = DW'(i_delay_ticks);
    assign w_load = (w_delay_masked == '0) ? DW'(1) : w_delay_masked;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_idle) begin
            case (i_head.op.kind)
                i2cm_pkg::CMD_START: n_phase = i2cm_pkg::PH_ST_A;
                i2cm_pkg::CMD_STOP:  n_phase = i2cm_pkg::PH_SP_A;
                i2cm_pkg::CMD_WRITE: n_phase = i2cm_pkg::PH_WR_LOW;
                i2cm_pkg::CMD_READ:  n_phase = i2cm_pkg::PH_RD_LOW;
                default:             n_phase = i2cm_pkg::PH_IDLE;
            endcase
        end else if (w_fire) begin
            case (r_phase)
                i2cm_pkg::PH_ST_A:    n_phase = i2cm_pkg::PH_ST_B;
                i2cm_pkg::PH_SP_A:    n_phase = i2cm_pkg::PH_SP_B;
                i2cm_pkg::PH_SP_B:    n_phase = i2cm_pkg::PH_SP_C;
                i2cm_pkg::PH_WR_LOW:  n_phase = i2cm_pkg::PH_WR_DATA;
                i2cm_pkg::PH_WR_DATA: n_phase = i2cm_pkg::PH_WR_HIGH;
                i2cm_pkg::PH_WR_HIGH: begin
                    n_phase = (w_bit_inc < i2cm_pkg::BITS_PER_BYTE) ?
                              i2cm_pkg::PH_WR_LOW : i2cm_pkg::PH_WA_REL;
                end
                i2cm_pkg::PH_WA_REL:  n_phase = i2cm_pkg::PH_WA_HIGH;
                i2cm_pkg::PH_WA_HIGH: n_phase = i2cm_pkg::PH_WA_END;
                i2cm_pkg::PH_RD_LOW:  n_phase = i2cm_pkg::PH_RD_HIGH;
                i2cm_pkg::PH_RD_HIGH: begin
                    n_phase = (w_bit_inc < i2cm_pkg::BITS_PER_BYTE) ?
                              i2cm_pkg::PH_RD_LOW : i2cm_pkg::PH_AK_LOW;
                end
                i2cm_pkg::PH_AK_LOW:  n_phase = i2cm_pkg::PH_AK_HIGH;
                default:              n_phase = i2cm_pkg::PH_IDLE;
            endcase
        end
    end

    // Bus levels, shifter, counters
    always_comb begin
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_received   = r_received;
        n_nack       = r_nack;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_wait       = r_wait;
        if (w_idle) begin
            if (i_head.op.kind != i2cm_pkg::CMD_NONE) begin
                n_ack_choice = i_head.op.send_ack;
                n_bit_index  = '0;
                n_wait       = w_load;
            end
            case (i_head.op.kind)
                i2cm_pkg::CMD_START: begin
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                end
                i2cm_pkg::CMD_STOP: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                i2cm_pkg::CMD_WRITE: begin
                    n_shift = i_head.op.tx_byte;
                    n_scl   = 1'b0;
                end
                i2cm_pkg::CMD_READ: begin
                    n_shift = '0;
                    n_sda   = 1'b1;
                    n_scl   = 1'b0;
                end
                default: ;
            endcase
        end else if (!w_fire) begin
            n_wait = r_wait - DW'(1);
        end else begin
            n_wait = w_done ? '0 : w_load;
            case (r_phase)
                i2cm_pkg::PH_ST_A:    n_sda = 1'b0;
                i2cm_pkg::PH_ST_B:    n_scl = 1'b0;
                i2cm_pkg::PH_SP_A:    n_scl = 1'b1;
                i2cm_pkg::PH_SP_B:    n_sda = 1'b1;
                i2cm_pkg::PH_WR_LOW: begin
                    n_sda   = r_shift[7];
                    n_shift = {r_shift[6:0], 1'b0};
                end
                i2cm_pkg::PH_WR_DATA: n_scl = 1'b1;
                i2cm_pkg::PH_WR_HIGH: begin
                    n_bit_index = w_bit_inc;
                    n_scl       = 1'b0;
                    // release SDA for the slave's acknowledge
                    if (w_bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_sda = 1'b1;
                    end
                end
                i2cm_pkg::PH_WA_REL:  n_scl = 1'b1;
                i2cm_pkg::PH_WA_HIGH: begin
                    n_nack = i_head.op.sda_in;
                    n_scl  = 1'b0;
                end
                i2cm_pkg::PH_RD_LOW: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_head.op.sda_in};
                end
                i2cm_pkg::PH_RD_HIGH: begin
                    n_bit_index = w_bit_inc;
                    n_scl       = 1'b0;
                    if (w_bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_sda = !r_ack_choice;
                    end
                end
                i2cm_pkg::PH_AK_LOW:  n_scl = 1'b1;
                i2cm_pkg::PH_AK_HIGH: begin
                    n_scl      = 1'b0;
                    n_sda      = 1'b1;
                    n_received = r_shift;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cm_pkg::PH_IDLE;
            r_bit_index  <= '0;
            r_shift      <= '0;
            r_wait       <= '0;
            r_ack_choice <= 1'b0;
            r_received   <= '0;
            r_nack       <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_shift      <= n_shift;
            r_wait       <= n_wait;
            r_ack_choice <= n_ack_choice;
            r_received   <= n_received;
            r_nack       <= n_nack;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

    // Result register: hold until the transaction completes downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_pop) begin
            r_res_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.scl_out   <= n_scl;
            r_res.sda_out   <= n_sda;
            r_res.busy_res  <= (n_phase != i2cm_pkg::PH_IDLE);
            r_res.done_res  <= w_done;
            r_res.rx_byte   <= n_received;
            r_res.nack_seen <= n_nack;
        end
    end

    assign o_result.valid   = r_res_valid;
    assign o_result.payload = r_res;

endmodule
